/* rtl/tps_pkg.sv */
package tps_pkg;

    localparam int TET_ID_WIDTH_DEF     = 24;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W            = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_A = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_B = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_C = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_D = 4'd3;

    localparam logic signed [31:0] PLANE_C_RESET = 32'sd65536;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [63:0] fval_t;

    // Index 0 is x, 1 is y, 2 is z
    typedef coord_t [2:0] vec_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
    } plane_t;

    // Crossing between corner a (the far side) and corner b
    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
    } pair_t;

    typedef pair_t [2:0] tri_t;

    typedef struct packed {
        vec_t  [3:0] corner;
        fval_t [3:0] fval;
        logic  [1:0] ntri;
        tri_t  [2:0] tris;
    } job_t;

    function automatic logic [63:0] mag64(input fval_t v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

endpackage

/* rtl/tps_queue.sv */
module tps_queue
    import tps_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wptr_reg, wptr_next;
    logic              rptr_reg, rptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

endmodule

/* rtl/tps_front.sv */
module tps_front
    import tps_pkg::*;
#(
    parameter int TET_ID_WIDTH = TET_ID_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  plane_t                  plane,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [31:0]      corner_x,
    input  logic signed [31:0]      corner_y,
    input  logic signed [31:0]      corner_z,
    input  logic [TET_ID_WIDTH-1:0] tet_number,
    output logic                    push_valid,
    input  logic                    push_ready,
    output job_t                    push_job,
    output logic [TET_ID_WIDTH-1:0] push_tet
);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_SUM   = 2'd1;
    localparam logic [1:0] F_CLASS = 2'd2;

    logic [1:0]              st_reg, st_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic signed [63:0]      pa_reg, pb_reg, pc_reg;
    logic signed [31:0]      d_reg;
    vec_t                    cur_reg;
    logic [TET_ID_WIDTH-1:0] tet_reg;
    vec_t                    corner_reg [4];
    fval_t                   fval_reg [4];

    logic                    accept;
    logic signed [65:0]      sum66;
    fval_t                   fsat;

    logic [2:0]              nneg, npos;
    logic [1:0]              rank_a [4];
    logic [1:0]              rank_d [4];
    logic [1:0]              ord_a [4];
    logic [1:0]              ord_d [4];
    tri_t [2:0]              tris;
    logic [1:0]              k;

    function automatic pair_t mkpair(input logic [1:0] a, input logic [1:0] b);
        pair_t p;
        p.a = a;
        p.b = b;
        return p;
    endfunction

    assign in_ready = (st_reg == F_IDLE);
    assign accept   = in_valid && in_ready;

    // Plane value: exact sum, then clamp to 64 bits
    always_comb
    begin
        sum66 = 66'(pa_reg) + 66'(pb_reg) + 66'(pc_reg) + 66'($signed({d_reg, 16'h0000}));
        if (sum66[65:63] == 3'b000 || sum66[65:63] == 3'b111)
        begin
            fsat = sum66[63:0];
        end
        else if (sum66[65])
        begin
            fsat = {1'b1, 63'd0};
        end
        else
        begin
            fsat = {1'b0, {63{1'b1}}};
        end
    end

    // Classify: sign counts, stable ranks in both directions, triangle list
    always_comb
    begin
        nneg = 3'd0;
        npos = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (fval_reg[i] < 0)
            begin
                nneg = nneg + 3'd1;
            end
            if (fval_reg[i] > 0)
            begin
                npos = npos + 3'd1;
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            rank_a[i] = 2'd0;
            rank_d[i] = 2'd0;
            for (int j = 0; j < 4; j++)
            begin
                if (j != i)
                begin
                    if (fval_reg[j] < fval_reg[i] || (j < i && fval_reg[j] == fval_reg[i]))
                    begin
                        rank_a[i] = rank_a[i] + 2'd1;
                    end
                    if (fval_reg[j] > fval_reg[i] || (j < i && fval_reg[j] == fval_reg[i]))
                    begin
                        rank_d[i] = rank_d[i] + 2'd1;
                    end
                end
            end
        end
        for (int r = 0; r < 4; r++)
        begin
            ord_a[r] = 2'd0;
            ord_d[r] = 2'd0;
            for (int i = 0; i < 4; i++)
            begin
                if (rank_a[i] == 2'(r))
                begin
                    ord_a[r] = 2'(i);
                end
                if (rank_d[i] == 2'(r))
                begin
                    ord_d[r] = 2'(i);
                end
            end
        end
        tris = '0;
        k    = 2'd0;
        if (nneg == 3'd1)
        begin
            tris[k] = {mkpair(ord_a[0], ord_a[3]), mkpair(ord_a[0], ord_a[2]),
                       mkpair(ord_a[0], ord_a[1])};
            k = k + 2'd1;
        end
        if (npos == 3'd1)
        begin
            tris[k] = {mkpair(ord_d[0], ord_d[3]), mkpair(ord_d[0], ord_d[2]),
                       mkpair(ord_d[0], ord_d[1])};
            k = k + 2'd1;
        end
        if (nneg == 3'd2)
        begin
            // (P0, P1, P3) then (P0, P3, P2)
            tris[k] = {mkpair(ord_a[1], ord_a[3]), mkpair(ord_a[0], ord_a[3]),
                       mkpair(ord_a[0], ord_a[2])};
            k = k + 2'd1;
            tris[k] = {mkpair(ord_a[1], ord_a[2]), mkpair(ord_a[1], ord_a[3]),
                       mkpair(ord_a[0], ord_a[2])};
            k = k + 2'd1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            push_job.corner[i] = corner_reg[i];
            push_job.fval[i]   = fval_reg[i];
        end
        push_job.ntri = k;
        push_job.tris = tris;
        push_tet      = tet_reg;
        push_valid    = (st_reg == F_CLASS) && (k != 2'd0);
    end

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        unique case (st_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    st_next = F_SUM;
                end
            end
            F_SUM:
            begin
                if (cnt_reg == 2'd3)
                begin
                    cnt_next = 2'd0;
                    st_next  = F_CLASS;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                    st_next  = F_IDLE;
                end
            end
            F_CLASS:
            begin
                if (k == 2'd0 || push_ready)
                begin
                    st_next = F_IDLE;
                end
            end
            default:
            begin
                st_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= F_IDLE;
            cnt_reg <= 2'd0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pa_reg     <= plane.a * corner_x;
            pb_reg     <= plane.b * corner_y;
            pc_reg     <= plane.c * corner_z;
            d_reg      <= plane.d;
            cur_reg[0] <= corner_x;
            cur_reg[1] <= corner_y;
            cur_reg[2] <= corner_z;
            tet_reg    <= tet_number;
        end
        if (st_reg == F_SUM)
        begin
            corner_reg[cnt_reg] <= cur_reg;
            fval_reg[cnt_reg]   <= fsat;
        end
    end

endmodule

/* rtl/tps_back.sv */
module tps_back
    import tps_pkg::*;
#(
    parameter int TET_ID_WIDTH     = TET_ID_WIDTH_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  plane_t                  plane,
    input  logic                    job_valid,
    output logic                    job_ready,
    input  job_t                    job,
    input  logic [TET_ID_WIDTH-1:0] job_tet,
    output logic                    out_valid,
    input  logic                    out_ready,
    output vec_t                    out_p0,
    output vec_t                    out_p1,
    output vec_t                    out_p2,
    output logic [TET_ID_WIDTH-1:0] out_tet,
    output logic                    out_last
);

    localparam int WF   = WEIGHT_FRAC_BITS;
    localparam int DC_W = $clog2(WF);

    localparam logic [2:0] B_IDLE    = 3'd0;
    localparam logic [2:0] B_DIVINIT = 3'd1;
    localparam logic [2:0] B_DIV     = 3'd2;
    localparam logic [2:0] B_IMUL    = 3'd3;
    localparam logic [2:0] B_IADD    = 3'd4;
    localparam logic [2:0] B_FMUL    = 3'd5;
    localparam logic [2:0] B_FACC    = 3'd6;
    localparam logic [2:0] B_OUT     = 3'd7;

    logic [2:0]              st_reg, st_next;
    job_t                    job_reg;
    logic [TET_ID_WIDTH-1:0] tet_reg;
    logic [1:0]              tri_reg;
    logic [1:0]              vtx_reg;
    logic [1:0]              axis_reg;
    logic [3:0]              step_reg;
    logic [DC_W-1:0]         dcnt_reg;
    logic [63:0]             den_reg, rem_reg;
    logic [WF-1:0]           w_reg;
    logic signed [69:0]      prod_reg;
    vec_t                    vert_reg [3];
    logic signed [67:0]      n_reg [3];
    logic signed [103:0]     s_reg;

    logic                    out_valid_reg;
    vec_t                    p0_reg, p1_reg, p2_reg;
    logic [TET_ID_WIDTH-1:0] otet_reg;
    logic                    last_reg;

    pair_t                   pr;
    vec_t                    va, vb;
    logic [63:0]             nb, ma, dsub;
    logic signed [32:0]      diff;
    logic signed [32:0]      e1 [3];
    logic signed [32:0]      e2 [3];
    logic signed [34:0]      mul_a, mul_b;
    logic signed [69:0]      prod_c;
    logic signed [69:0]      tsum;
    logic signed [69:0]      tsh;
    logic [3:0]              stm6;
    logic [1:0]              nidx;
    logic signed [67:0]      nsel;
    logic signed [31:0]      coef;
    logic signed [103:0]     pext;
    logic                    out_load;
    logic                    last_tri;

    assign job_ready = (st_reg == B_IDLE);
    assign pr        = job_reg.tris[tri_reg][vtx_reg];
    assign va        = job_reg.corner[pr.a];
    assign vb        = job_reg.corner[pr.b];
    assign nb        = mag64(job_reg.fval[pr.b]);
    assign ma        = mag64(job_reg.fval[pr.a]);
    assign dsub      = den_reg - rem_reg;
    assign diff      = $signed({va[axis_reg][31], va[axis_reg]})
                     - $signed({vb[axis_reg][31], vb[axis_reg]});
    assign stm6      = step_reg - 4'd6;
    assign nidx      = (step_reg < 4'd6) ? step_reg[2:1] : stm6[2:1];
    assign nsel      = n_reg[nidx];
    assign out_load  = !out_valid_reg || out_ready;
    assign last_tri  = (tri_reg == job_reg.ntri - 2'd1);
    assign tsum      = prod_reg + (70'sd1 <<< (WF - 1));
    assign tsh       = tsum >>> WF;
    assign pext      = 104'(prod_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = $signed({vert_reg[1][i][31], vert_reg[1][i]})
                  - $signed({vert_reg[0][i][31], vert_reg[0][i]});
            e2[i] = $signed({vert_reg[2][i][31], vert_reg[2][i]})
                  - $signed({vert_reg[0][i][31], vert_reg[0][i]});
        end
    end

    always_comb
    begin
        case (nidx)
            2'd0:    coef = plane.a;
            2'd1:    coef = plane.b;
            default: coef = plane.c;
        endcase
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (st_reg == B_IMUL)
        begin
            mul_a = 35'(diff);
            mul_b = 35'(w_reg);
        end
        else
        begin
            case (step_reg)
                4'd0:
                begin
                    mul_a = 35'(e1[1]);
                    mul_b = 35'(e2[2]);
                end
                4'd1:
                begin
                    mul_a = 35'(e1[2]);
                    mul_b = 35'(e2[1]);
                end
                4'd2:
                begin
                    mul_a = 35'(e1[2]);
                    mul_b = 35'(e2[0]);
                end
                4'd3:
                begin
                    mul_a = 35'(e1[0]);
                    mul_b = 35'(e2[2]);
                end
                4'd4:
                begin
                    mul_a = 35'(e1[0]);
                    mul_b = 35'(e2[1]);
                end
                4'd5:
                begin
                    mul_a = 35'(e1[1]);
                    mul_b = 35'(e2[0]);
                end
                default:
                begin
                    mul_a = 35'(coef);
                    if (step_reg[0])
                    begin
                        mul_b = 35'($signed(nsel[67:34]));
                    end
                    else
                    begin
                        mul_b = $signed({1'b0, nsel[33:0]});
                    end
                end
            endcase
        end
    end

    assign prod_c = mul_a * mul_b;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    st_next = B_DIVINIT;
                end
            end
            B_DIVINIT:
            begin
                st_next = B_DIV;
            end
            B_DIV:
            begin
                if (dcnt_reg == DC_W'(WF - 1))
                begin
                    st_next = B_IMUL;
                end
            end
            B_IMUL:
            begin
                st_next = B_IADD;
            end
            B_IADD:
            begin
                if (axis_reg != 2'd2)
                begin
                    st_next = B_IMUL;
                end
                else if (vtx_reg == 2'd2)
                begin
                    st_next = B_FMUL;
                end
                else
                begin
                    st_next = B_DIVINIT;
                end
            end
            B_FMUL:
            begin
                st_next = B_FACC;
            end
            B_FACC:
            begin
                st_next = (step_reg == 4'd11) ? B_OUT : B_FMUL;
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    st_next = last_tri ? B_IDLE : B_DIVINIT;
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == B_OUT && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            B_IDLE:
            begin
                job_reg <= job;
                tet_reg <= job_tet;
                tri_reg <= 2'd0;
                vtx_reg <= 2'd0;
            end
            B_DIVINIT:
            begin
                den_reg  <= nb + ma;
                rem_reg  <= nb;
                w_reg    <= '0;
                dcnt_reg <= '0;
            end
            B_DIV:
            begin
                if (rem_reg >= dsub)
                begin
                    rem_reg <= rem_reg - dsub;
                    w_reg   <= {w_reg[WF-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_reg + rem_reg;
                    w_reg   <= {w_reg[WF-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
                axis_reg <= 2'd0;
            end
            B_IMUL:
            begin
                prod_reg <= prod_c;
            end
            B_IADD:
            begin
                vert_reg[vtx_reg][axis_reg] <= vb[axis_reg] + tsh[31:0];
                axis_reg <= axis_reg + 2'd1;
                if (axis_reg == 2'd2)
                begin
                    vtx_reg <= vtx_reg + 2'd1;
                    if (vtx_reg == 2'd2)
                    begin
                        step_reg <= 4'd0;
                        s_reg    <= '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            n_reg[i] <= '0;
                        end
                    end
                end
            end
            B_FMUL:
            begin
                prod_reg <= prod_c;
            end
            B_FACC:
            begin
                if (step_reg < 4'd6)
                begin
                    if (step_reg[0])
                    begin
                        n_reg[nidx] <= n_reg[nidx] - prod_reg[67:0];
                    end
                    else
                    begin
                        n_reg[nidx] <= n_reg[nidx] + prod_reg[67:0];
                    end
                end
                else if (step_reg[0])
                begin
                    s_reg <= s_reg + (pext <<< 34);
                end
                else
                begin
                    s_reg <= s_reg + pext;
                end
                step_reg <= step_reg + 4'd1;
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    // Reverse the winding when the normal opposes the plane normal
                    p0_reg   <= s_reg[103] ? vert_reg[2] : vert_reg[0];
                    p1_reg   <= vert_reg[1];
                    p2_reg   <= s_reg[103] ? vert_reg[0] : vert_reg[2];
                    otet_reg <= tet_reg;
                    last_reg <= last_tri;
                    tri_reg  <= tri_reg + 2'd1;
                    vtx_reg  <= 2'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_p0    = p0_reg;
    assign out_p1    = p1_reg;
    assign out_p2    = p2_reg;
    assign out_tet   = otet_reg;
    assign out_last  = last_reg;

endmodule

/* rtl/tet_plane_slicer.sv */
// Plane slicer for a stream of tetrahedra.
// Input channel (in_valid/in_ready): one corner item per handshake, signed
// Q16.16 x, y, z and the tet number; four consecutive items form one tet,
// and only the fourth item's tet number is kept.
// Output channel (out_valid/out_ready): one triangle item per handshake,
// three vertices in winding order, the source tet and a last-triangle flag.
// Config channel (cfg_valid/cfg_ready, always ready): writes plane a, b, c, d
// by index 0..3; other indexes are dropped. Write only while the block is idle.
// The front takes a new corner only after it has stored the last one, and
// after the fourth corner it holds in its classify step until the tet is
// pushed. A two-entry tet queue sits between front and back, so the front
// keeps taking corners while the back works. The back takes a new tet only
// when done with the last one. Per vertex it runs the restoring weight
// divider, one bit a cycle, then three passes through the shared multiplier;
// after the third vertex come the orientation test and hand-off.
// Reset clears the corner count, the tet queue and the output valid flag; the
// plane resets to z = 0. A stalled receiver holds the output item, then
// the back, then fills the queue, and finally drops in_ready.
module tet_plane_slicer
    import tps_pkg::*;
#(
    parameter int TET_ID_WIDTH     = TET_ID_WIDTH_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [31:0]      corner_x,
    input  logic signed [31:0]      corner_y,
    input  logic signed [31:0]      corner_z,
    input  logic [TET_ID_WIDTH-1:0] tet_number,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [31:0]      p0_x,
    output logic signed [31:0]      p0_y,
    output logic signed [31:0]      p0_z,
    output logic signed [31:0]      p1_x,
    output logic signed [31:0]      p1_y,
    output logic signed [31:0]      p1_z,
    output logic signed [31:0]      p2_x,
    output logic signed [31:0]      p2_y,
    output logic signed [31:0]      p2_z,
    output logic [TET_ID_WIDTH-1:0] source_tet,
    output logic                    last_triangle
);

    localparam int QW = $bits(job_t) + TET_ID_WIDTH;

    plane_t                  plane_reg;
    logic                    push_valid, push_ready;
    job_t                    push_job;
    logic [TET_ID_WIDTH-1:0] push_tet;
    logic                    job_valid, job_ready;
    logic [QW-1:0]           job_data;
    vec_t                    o_p0, o_p1, o_p2;

    // Plane registers; the user must write them only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.a <= '0;
            plane_reg.b <= '0;
            plane_reg.c <= PLANE_C_RESET;
            plane_reg.d <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PLANE_A: plane_reg.a <= cfg_data;
                REG_PLANE_B: plane_reg.b <= cfg_data;
                REG_PLANE_C: plane_reg.c <= cfg_data;
                REG_PLANE_D: plane_reg.d <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front: plane value per corner, classify and sort on the fourth
    tps_front #(
        .TET_ID_WIDTH (TET_ID_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .plane      (plane_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .corner_x   (corner_x),
        .corner_y   (corner_y),
        .corner_z   (corner_z),
        .tet_number (tet_number),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .push_tet   (push_tet)
    );

    // Hold up to two classified tets
    tps_queue #(
        .DATA_W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_tet, push_job}),
        .out_valid (job_valid),
        .out_ready (job_ready),
        .out_data  (job_data)
    );

    // Back: edge weights, interpolation, winding test, output register
    tps_back #(
        .TET_ID_WIDTH     (TET_ID_WIDTH),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .plane     (plane_reg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job_data[$bits(job_t)-1:0]),
        .job_tet   (job_data[QW-1:$bits(job_t)]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_p0    (o_p0),
        .out_p1    (o_p1),
        .out_p2    (o_p2),
        .out_tet   (source_tet),
        .out_last  (last_triangle)
    );

    assign p0_x = o_p0[0];
    assign p0_y = o_p0[1];
    assign p0_z = o_p0[2];
    assign p1_x = o_p1[0];
    assign p1_y = o_p1[1];
    assign p1_z = o_p1[2];
    assign p2_x = o_p2[0];
    assign p2_y = o_p2[1];
    assign p2_z = o_p2[2];

`ifndef SYNTH
    // The front never takes a corner while it offers a tet to the queue
    a_front_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && push_valid))
        else $error("front accepts a corner while pushing a tet");

    // After a push the front leaves its classify step
    a_push_once: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_ready |=> !push_valid)
        else $error("tet pushed twice");

    // The back goes busy right after taking a tet
    a_back_busy: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready |=> !job_ready)
        else $error("back took a tet without starting it");
`endif

endmodule

/* dv/tps_checker.sv */
module tps_checker
    import tps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic signed [31:0]   corner_x,
    input  logic signed [31:0]   corner_y,
    input  logic signed [31:0]   corner_z,
    input  logic [23:0]          tet_number,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic signed [31:0]   p0_x,
    input  logic signed [31:0]   p0_y,
    input  logic signed [31:0]   p0_z,
    input  logic signed [31:0]   p1_x,
    input  logic signed [31:0]   p1_y,
    input  logic signed [31:0]   p1_z,
    input  logic signed [31:0]   p2_x,
    input  logic signed [31:0]   p2_y,
    input  logic signed [31:0]   p2_z,
    input  logic [23:0]          source_tet,
    input  logic                 last_triangle,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WF = WEIGHT_FRAC_BITS_DEF;

    typedef longint pt3_t [3];

    typedef struct {
        logic [31:0] v [9];
        logic [23:0] id;
        logic        last;
    } triangle_s;

    triangle_s tri_q [$];

    longint pa, pb, pc, pd;
    longint held_pos [3][3];
    longint held_f [3];
    int     held_cnt;

    initial fail_count = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic longint plane_eval(input longint x, input longint y, input longint z);
        logic signed [71:0] s;
        s = pa * x + pb * y + pc * z + pd * 65536;
        if (s[71:63] != {9{s[63]}})
            return s[71] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
        return s[63:0];
    endfunction

    // Bit-serial weight, same wrap behavior as a 64-bit unsigned datapath
    function automatic logic [31:0] cross_weight(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] r;
        logic [31:0] w;
        r = num;
        w = 0;
        for (int i = 0; i < WF; i++)
        begin
            if (r >= den - r)
            begin
                r = r - (den - r);
                w = {w[30:0], 1'b1};
            end
            else
            begin
                r = r + r;
                w = w << 1;
            end
        end
        return w;
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? 64'd0 - v : v;
    endfunction

    function automatic void crossing(input pt3_t va, input longint fa, input pt3_t vb,
                                     input longint fb, output pt3_t p);
        logic [31:0] w;
        longint t;
        w = cross_weight(abs64(fb), abs64(fb) + abs64(fa));
        for (int k = 0; k < 3; k++)
        begin
            t = (va[k] - vb[k]) * longint'(w) + (longint'(1) << (WF - 1));
            p[k] = vb[k] + (t >>> WF);
        end
    endfunction

    function automatic void push_triangle(input pt3_t q0, input pt3_t q1, input pt3_t q2,
                                          input logic [23:0] id);
        longint e1 [3];
        longint e2 [3];
        logic signed [127:0] s;
        triangle_s t;
        pt3_t first;
        pt3_t third;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = q1[i] - q0[i];
            e2[i] = q2[i] - q0[i];
        end
        s = pa * e1[1] * e2[2] - pa * e1[2] * e2[1] + pb * e1[2] * e2[0]
          - pb * e1[0] * e2[2] + pc * e1[0] * e2[1] - pc * e1[1] * e2[0];
        // reverse winding when the normal opposes the plane normal
        first = (s < 0) ? q2 : q0;
        third = (s < 0) ? q0 : q2;
        for (int j = 0; j < 3; j++)
        begin
            t.v[j]     = first[j][31:0];
            t.v[3 + j] = q1[j][31:0];
            t.v[6 + j] = third[j][31:0];
        end
        t.id = id;
        t.last = 1'b0;
        tri_q = {tri_q, t};
    endfunction

    function automatic void order_by_f(input longint f [4], input bit asc, output int ord [4]);
        int tmp;
        for (int i = 0; i < 4; i++)
            ord[i] = i;
        for (int i = 1; i < 4; i++)
            for (int j = i; j > 0; j--)
            begin
                if (asc ? !(f[ord[j]] < f[ord[j-1]]) : !(f[ord[j]] > f[ord[j-1]]))
                    break;
                tmp = ord[j];
                ord[j] = ord[j-1];
                ord[j-1] = tmp;
            end
    endfunction

    function automatic void slice_tet(input pt3_t cur, input logic [23:0] id);
        pt3_t cv [4];
        pt3_t q [4];
        longint f [4];
        int ord [4];
        int neg;
        int pos;
        int made;
        neg = 0;
        pos = 0;
        made = 0;
        for (int i = 0; i < 3; i++)
        begin
            cv[i] = held_pos[i];
            f[i] = held_f[i];
        end
        cv[3] = cur;
        f[3] = plane_eval(cur[0], cur[1], cur[2]);
        for (int i = 0; i < 4; i++)
        begin
            if (f[i] < 0) neg++;
            if (f[i] > 0) pos++;
        end
        // one corner below, then one corner above: a single fan triangle each
        for (int c = 0; c < 2; c++)
        begin
            if (c == 0 ? neg != 1 : pos != 1)
                continue;
            order_by_f(f, c == 0, ord);
            for (int i = 0; i < 3; i++)
                crossing(cv[ord[0]], f[ord[0]], cv[ord[i+1]], f[ord[i+1]], q[i]);
            push_triangle(q[0], q[1], q[2], id);
            made++;
        end
        // two below: a quad split into two triangles
        if (neg == 2)
        begin
            order_by_f(f, 1'b1, ord);
            crossing(cv[ord[0]], f[ord[0]], cv[ord[2]], f[ord[2]], q[0]);
            crossing(cv[ord[0]], f[ord[0]], cv[ord[3]], f[ord[3]], q[1]);
            crossing(cv[ord[1]], f[ord[1]], cv[ord[2]], f[ord[2]], q[2]);
            crossing(cv[ord[1]], f[ord[1]], cv[ord[3]], f[ord[3]], q[3]);
            push_triangle(q[0], q[1], q[3], id);
            push_triangle(q[0], q[3], q[2], id);
            made += 2;
        end
        if (made > 0)
            tri_q[tri_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa = 0;
            pb = 0;
            pc = 65536;
            pd = 0;
            held_cnt = 0;
            pending <= 0;
            tri_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PLANE_A: pa = longint'($signed(cfg_data));
                    REG_PLANE_B: pb = longint'($signed(cfg_data));
                    REG_PLANE_C: pc = longint'($signed(cfg_data));
                    REG_PLANE_D: pd = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                pt3_t cur;
                cur[0] = corner_x;
                cur[1] = corner_y;
                cur[2] = corner_z;
                if (held_cnt < 3)
                begin
                    held_pos[held_cnt] = cur;
                    held_f[held_cnt] = plane_eval(cur[0], cur[1], cur[2]);
                    held_cnt = held_cnt + 1;
                end
                else
                begin
                    held_cnt = 0;
                    slice_tet(cur, tet_number);
                end
            end
            if (out_valid && out_ready)
            begin
                if (tri_q.size() == 0)
                    report("unexpected triangle", source_tet, 0);
                else
                begin
                    triangle_s w;
                    logic [31:0] got [9];
                    w = tri_q.pop_front();
                    got = '{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z};
                    for (int i = 0; i < 9; i++)
                        if (got[i] !== w.v[i])
                            report($sformatf("vertex %0d axis %0d", i / 3, i % 3),
                                   got[i], w.v[i]);
                    if (source_tet !== w.id)
                        report("source_tet", source_tet, w.id);
                    if (last_triangle !== w.last)
                        report("last_triangle", last_triangle, w.last);
                end
            end
            pending <= tri_q.size();
        end
    end

endmodule

/* dv/tb_top.sv */
module tb_top;
    import tps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    // unmapped register index, the block must drop writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic signed [31:0]   corner_x = '0;
    logic signed [31:0]   corner_y = '0;
    logic signed [31:0]   corner_z = '0;
    logic [23:0]          tet_number = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [31:0]   p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
    logic [23:0]          source_tet;
    logic                 last_triangle;
    int                   fail_count;
    int                   pending;

    bit in_gaps = 1'b0;
    bit out_gaps = 1'b0;
    int hold_left = 0;
    int cycles = 0;

    tet_plane_slicer dut (.*);

    tps_checker chk (.*);

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: give up far beyond the slowest legal run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: after each accepted triangle, draw a random stall when out_gaps is set
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (out_valid && out_ready)
        begin
            hold_left = out_gaps ? $urandom_range(0, 17) : 0;
            out_ready <= (hold_left == 0);
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= (hold_left == 0);
        end
        else
            out_ready <= 1'b1;
    end

    // Drive one corner item; call at a rising edge, returns at the accepting edge
    task automatic send_corner(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [23:0] id);
        int gap;
        gap = in_gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        corner_x <= x;
        corner_y <= y;
        corner_z <= z;
        tet_number <= id;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid, then hold until every triangle is back and the back end settles
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (400) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_plane(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input logic [31:0] d);
        write_reg(REG_PLANE_A, a);
        write_reg(REG_PLANE_B, b);
        write_reg(REG_PLANE_C, c);
        write_reg(REG_PLANE_D, d);
        write_reg(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Tet on a unit footprint, heights given in whole units; first three ids are noise
    task automatic height_tet(input int z0, input int z1, input int z2, input int z3,
                              input logic [23:0] id);
        int zs [4];
        zs = '{z0, z1, z2, z3};
        for (int k = 0; k < 4; k++)
            send_corner((k == 1) ? 32'h10000 : 32'h0, (k == 2) ? 32'h10000 : 32'h0,
                        zs[k] * 65536, (k == 3) ? id : 24'($urandom));
    endtask

    // Small grid coordinates hit zeros and ties; a few tets use raw 32-bit noise
    task automatic random_tet();
        bit noisy;
        logic [31:0] v [3];
        noisy = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < 3; j++)
                v[j] = noisy ? $urandom
                     : (($urandom_range(0, 1) == 0) ? (($urandom_range(0, 8) - 4) * 65536)
                                                    : ($urandom_range(0, 1 << 19) - (1 << 18)));
            send_corner(v[0], v[1], v[2], 24'($urandom));
        end
    endtask

    function automatic logic [31:0] random_coef();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return ($urandom_range(0, 1) == 0) ? 32'h80000000 : 32'h7fffffff;
            default: return ($urandom_range(0, 6) - 3) * 65536;
        endcase
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, plane z = 0 from reset
        height_tet(-1, 1, 1, 1, 24'h000000);   // one below
        height_tet(1, -1, -2, -1, 24'hffffff); // one above, with tied values
        height_tet(-1, -2, 1, 2, 24'h5a5a5a);  // two below
        height_tet(-1, 1, 0, 0, 24'ha5a5a5);   // one below and one above
        height_tet(-1, -1, 1, 0, 24'h123456);  // two below plus one above
        height_tet(0, 0, 0, 0, 24'h654321);    // flat, no output
        drain();

        // Extreme plane: the third corner's plane value saturates
        write_plane(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_corner(32'h80000000, 32'h80000000, 32'h80000000, 24'h1);
        send_corner(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 24'h2);
        send_corner(32'h80000000, 32'h7fffffff, 32'h0, 24'h3);
        send_corner(32'h7fffffff, 32'h80000000, 32'hffffffff, 24'h800000);
        drain();

        // Random phases; input gaps alternate, output stalls in two phases of every three
        for (int ph = 0; ph < 6; ph++)
        begin
            in_gaps = ph[0];
            out_gaps = (ph % 3) != 0;
            if (ph == 0)
                write_plane(32'h0, 32'h0, 32'h10000, 32'h0);
            else
                write_plane(random_coef(), random_coef(), random_coef(), random_coef());
            for (int t = 0; t < 17; t++)
                random_tet();
            drain();
        end

        // Null plane: every value is zero, nothing comes out
        write_plane(32'h0, 32'h0, 32'h0, 32'h0);
        height_tet(-3, 2, 1, -1, 24'h00ff00);
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/tps_pkg.sv
rtl/tps_queue.sv
rtl/tps_front.sv
rtl/tps_back.sv
rtl/tet_plane_slicer.sv
dv/tps_checker.sv
dv/tb_top.sv
